FILE: sv/mpr_pkg.sv
// Shared types, codes and decision functions for the maze path recorder and replayer.
// Depends on nothing; the RTL files refer to it by scoped names and the testbench imports it.

package mpr_pkg;

    // Sizes of the turn store and of the length counter.
    localparam int PATH_MAX = 31;
    localparam int DEPTH    = PATH_MAX + 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LEN_W    = $clog2(PATH_MAX + 2);

    typedef logic [2:0]        t_turn;
    typedef logic [2:0]        t_line;
    typedef logic [1:0]        t_status;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;

    // Turn codes.
    localparam t_turn T_STRAIGHT = 3'd0;
    localparam t_turn T_LEFT     = 3'd1;
    localparam t_turn T_RIGHT    = 3'd2;
    localparam t_turn T_UTURN    = 3'd3;
    localparam t_turn T_FINISH   = 3'd4;
    localparam t_turn T_STOP     = 3'd5;

    // Line kind codes.
    localparam t_line L_NONE     = 3'd0;
    localparam t_line L_STRAIGHT = 3'd1;
    localparam t_line L_LEFT     = 3'd2;
    localparam t_line L_RIGHT    = 3'd3;
    localparam t_line L_FULL     = 3'd4;

    // Status codes.
    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_SOLVED      = 2'd1;
    localparam t_status ST_REPLAY_DONE = 2'd2;
    localparam t_status ST_FAILED      = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_SH_MID_RD,
        S_SH_MID_CHK,
        S_SH_A_CHK,
        S_REV_INIT,
        S_REV_CHK,
        S_REV_RJ,
        S_REV_WI,
        S_REV_WJ,
        S_REV_MID_W,
        S_REV_END,
        S_RP_RD,
        S_RP_DATA,
        S_DONE
    } t_state;

    // Turn chosen at a junction while exploring.
    function automatic t_turn f_pick_turn(input t_line entry, input t_line hist,
                                          input t_line ex, input logic left_handed);
        t_turn side;
        t_turn turn;
        side = left_handed ? T_LEFT : T_RIGHT;
        turn = T_STOP;
        if (entry == L_NONE) begin
            turn = T_UTURN;
        end else if (ex == L_NONE) begin
            if (hist == L_LEFT) turn = T_LEFT;
            else if (hist == L_RIGHT) turn = T_RIGHT;
            else if (hist == L_FULL) turn = side;
        end else if (ex == L_STRAIGHT) begin
            if (hist == L_FULL) turn = side;
            else if (hist == L_LEFT) turn = left_handed ? T_LEFT : T_STRAIGHT;
            else if (hist == L_RIGHT) turn = left_handed ? T_STRAIGHT : T_RIGHT;
        end else if (ex == L_FULL && hist == L_FULL) begin
            turn = T_FINISH;
        end
        return turn;
    endfunction

    // Replacement for the triple first, u-turn, last; both outer turns are at most right.
    function automatic t_turn f_shorten(input t_turn first, input t_turn last);
        t_turn repl;
        case ({first[1:0], last[1:0]})
            4'b00_00: repl = T_UTURN;
            4'b00_01: repl = T_RIGHT;
            4'b00_10: repl = T_LEFT;
            4'b01_00: repl = T_RIGHT;
            4'b01_01: repl = T_STRAIGHT;
            4'b01_10: repl = T_UTURN;
            4'b10_00: repl = T_LEFT;
            4'b10_01: repl = T_UTURN;
            4'b10_10: repl = T_STRAIGHT;
            default:  repl = T_STOP;
        endcase
        return repl;
    endfunction

    // Mirror a turn for the return journey.
    function automatic t_turn f_swap_side(input t_turn t);
        t_turn r;
        if (t == T_LEFT) r = T_RIGHT;
        else if (t == T_RIGHT) r = T_LEFT;
        else r = t;
        return r;
    endfunction

endpackage

FILE: sv/mpr_path_ram.sv
// Turn store: one write port and one read port with registered read data.
// Depends on mpr_pkg for the depth and the entry types.

module mpr_path_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  mpr_pkg::t_addr i_waddr,
    input  mpr_pkg::t_turn i_wdata,
    input  mpr_pkg::t_addr i_raddr,
    output mpr_pkg::t_turn o_rdata
);

    mpr_pkg::t_turn r_mem [mpr_pkg::DEPTH];
    mpr_pkg::t_turn r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/maze_path_recorder_replayer.sv
// Throughput: one item at a time; the sequencer owns the two-port turn store, and a new
// beat is taken in the cycle after a result is loaded into the output register.
// Reset (synchronous, active low) clears the length, the replay flag, the rule select and the
// output valid; the turn store is not cleared and needs no clearing pass.
// Depends on mpr_pkg and mpr_path_ram.

module maze_path_recorder_replayer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write port.
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,
    // Input channel.
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic [2:0]               i_entry_line_kind,
    input  logic [2:0]               i_history_line_kind,
    input  logic [2:0]               i_exit_line_kind,
    // Output channel.
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_turn_cmd,
    output logic [1:0]               o_status,
    output logic [5:0]               o_path_count,
    output logic                     o_solved_mode
);

    mpr_pkg::t_state  r_state, n_state;
    mpr_pkg::t_len    r_len, n_len;
    logic             r_solved, n_solved;
    logic             r_left_handed;
    logic             r_out_valid, n_out_valid;
    mpr_pkg::t_turn   r_turn, n_turn;
    mpr_pkg::t_status r_status, n_status;
    mpr_pkg::t_turn   r_tmp, n_tmp;
    mpr_pkg::t_addr   r_lo, n_lo;
    mpr_pkg::t_addr   r_hi, n_hi;
    mpr_pkg::t_addr   r_sh_addr, n_sh_addr;
    mpr_pkg::t_turn   r_o_turn;
    mpr_pkg::t_status r_o_status;
    mpr_pkg::t_len    r_o_count;
    logic             r_o_solved;

    logic             s_accept;
    logic             s_slot_free;
    mpr_pkg::t_turn   s_pick;
    mpr_pkg::t_len    s_delta;
    mpr_pkg::t_len    s_sum;
    logic             s_we;
    mpr_pkg::t_addr   s_waddr;
    mpr_pkg::t_turn   s_wdata;
    mpr_pkg::t_addr   s_raddr;
    mpr_pkg::t_turn   s_rdata;

    assign o_ready     = (r_state == mpr_pkg::S_IDLE);
    assign s_accept    = i_valid && o_ready;
    assign s_slot_free = !r_out_valid || i_ready;
    assign s_pick      = mpr_pkg::f_pick_turn(i_entry_line_kind, i_history_line_kind,
                                              i_exit_line_kind, r_left_handed);

    // Shared index unit: the path length plus a small offset chosen by the sequencer.
    assign s_sum = r_len + s_delta;

    mpr_path_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpr_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (i_cmd) begin
                        n_state = mpr_pkg::S_DONE;
                    end else if (r_solved) begin
                        if (r_len > mpr_pkg::t_len'(mpr_pkg::PATH_MAX)) n_state = mpr_pkg::S_DONE;
                        else n_state = mpr_pkg::S_RP_RD;
                    end else if (s_pick == mpr_pkg::T_STOP) begin
                        n_state = mpr_pkg::S_DONE;
                    end else if (r_len < mpr_pkg::t_len'(mpr_pkg::PATH_MAX)) begin
                        n_state = mpr_pkg::S_APPEND;
                    end else if (s_pick == mpr_pkg::T_FINISH) begin
                        n_state = mpr_pkg::S_REV_INIT;
                    end else begin
                        n_state = mpr_pkg::S_DONE;
                    end
                end
            end
            mpr_pkg::S_APPEND: begin
                if (r_turn == mpr_pkg::T_FINISH) n_state = mpr_pkg::S_REV_INIT;
                else if (r_len >= mpr_pkg::t_len'(2)) n_state = mpr_pkg::S_SH_MID_RD;
                else n_state = mpr_pkg::S_DONE;
            end
            mpr_pkg::S_SH_MID_RD:  n_state = mpr_pkg::S_SH_MID_CHK;
            mpr_pkg::S_SH_MID_CHK: begin
                if (s_rdata == mpr_pkg::T_UTURN) n_state = mpr_pkg::S_SH_A_CHK;
                else n_state = mpr_pkg::S_DONE;
            end
            mpr_pkg::S_SH_A_CHK:   n_state = mpr_pkg::S_DONE;
            mpr_pkg::S_REV_INIT:   n_state = mpr_pkg::S_REV_CHK;
            mpr_pkg::S_REV_CHK: begin
                if (r_lo < r_hi) n_state = mpr_pkg::S_REV_RJ;
                else if (r_lo == r_hi) n_state = mpr_pkg::S_REV_MID_W;
                else n_state = mpr_pkg::S_REV_END;
            end
            mpr_pkg::S_REV_RJ:     n_state = mpr_pkg::S_REV_WI;
            mpr_pkg::S_REV_WI:     n_state = mpr_pkg::S_REV_WJ;
            mpr_pkg::S_REV_WJ:     n_state = mpr_pkg::S_REV_CHK;
            mpr_pkg::S_REV_MID_W:  n_state = mpr_pkg::S_REV_END;
            mpr_pkg::S_REV_END:    n_state = mpr_pkg::S_DONE;
            mpr_pkg::S_RP_RD:      n_state = mpr_pkg::S_RP_DATA;
            mpr_pkg::S_RP_DATA:    n_state = mpr_pkg::S_DONE;
            mpr_pkg::S_DONE: begin
                if (s_slot_free) n_state = mpr_pkg::S_IDLE;
            end
            default:               n_state = mpr_pkg::S_IDLE;
        endcase
    end

    // Store port controls and index offset for each state.
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_lo;
        s_wdata = r_turn;
        s_raddr = r_lo;
        s_delta = '0;
        case (r_state)
            mpr_pkg::S_APPEND: begin
                s_we    = 1'b1;
                s_waddr = r_len[mpr_pkg::ADDR_W-1:0];
                s_wdata = r_turn;
                s_delta = mpr_pkg::t_len'(1);
            end
            mpr_pkg::S_SH_MID_RD: begin
                s_delta = -mpr_pkg::t_len'(2);
                s_raddr = s_sum[mpr_pkg::ADDR_W-1:0];
            end
            mpr_pkg::S_SH_MID_CHK: begin
                s_delta = -mpr_pkg::t_len'(3);
                s_raddr = s_sum[mpr_pkg::ADDR_W-1:0];
            end
            mpr_pkg::S_SH_A_CHK: begin
                s_delta = -mpr_pkg::t_len'(2);
                s_we    = (s_rdata <= mpr_pkg::T_RIGHT) && (r_turn <= mpr_pkg::T_RIGHT);
                s_waddr = r_sh_addr;
                s_wdata = mpr_pkg::f_shorten(s_rdata, r_turn);
            end
            mpr_pkg::S_REV_INIT: begin
                s_delta = -mpr_pkg::t_len'(1);
            end
            mpr_pkg::S_REV_CHK: begin
                s_raddr = r_lo;
            end
            mpr_pkg::S_REV_RJ: begin
                s_raddr = r_hi;
            end
            mpr_pkg::S_REV_WI: begin
                s_we    = 1'b1;
                s_waddr = r_lo;
                s_wdata = mpr_pkg::f_swap_side(s_rdata);
            end
            mpr_pkg::S_REV_WJ: begin
                s_we    = 1'b1;
                s_waddr = r_hi;
                s_wdata = mpr_pkg::f_swap_side(r_tmp);
            end
            mpr_pkg::S_REV_MID_W: begin
                s_we    = 1'b1;
                s_waddr = r_lo;
                s_wdata = mpr_pkg::f_swap_side(s_rdata);
            end
            mpr_pkg::S_REV_END: begin
                s_we    = 1'b1;
                s_waddr = r_len[mpr_pkg::ADDR_W-1:0];
                s_wdata = mpr_pkg::T_FINISH;
            end
            mpr_pkg::S_RP_RD: begin
                s_raddr = r_len[mpr_pkg::ADDR_W-1:0];
            end
            mpr_pkg::S_RP_DATA: begin
                s_delta = mpr_pkg::t_len'(1);
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    // Next values of the path state, the result and the reversal pointers.
    always_comb begin
        n_len       = r_len;
        n_solved    = r_solved;
        n_turn      = r_turn;
        n_status    = r_status;
        n_tmp       = r_tmp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_sh_addr   = r_sh_addr;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            mpr_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (i_cmd) begin
                        n_len    = '0;
                        n_solved = 1'b0;
                        n_turn   = mpr_pkg::T_STOP;
                        n_status = mpr_pkg::ST_OK;
                    end else if (r_solved) begin
                        n_turn   = mpr_pkg::T_STOP;
                        n_status = mpr_pkg::ST_FAILED;
                    end else begin
                        n_turn   = s_pick;
                        n_status = (s_pick == mpr_pkg::T_STOP) ? mpr_pkg::ST_FAILED
                                                               : mpr_pkg::ST_OK;
                    end
                end
            end
            mpr_pkg::S_APPEND: begin
                n_len = s_sum;
            end
            mpr_pkg::S_SH_MID_CHK: begin
                n_sh_addr = s_sum[mpr_pkg::ADDR_W-1:0];
            end
            mpr_pkg::S_SH_A_CHK: begin
                if (s_we) n_len = s_sum;
            end
            mpr_pkg::S_REV_INIT: begin
                n_lo = '0;
                n_hi = s_sum[mpr_pkg::ADDR_W-1:0];
            end
            mpr_pkg::S_REV_RJ: begin
                n_tmp = s_rdata;
            end
            mpr_pkg::S_REV_WJ: begin
                n_lo = r_lo + mpr_pkg::t_addr'(1);
                n_hi = r_hi - mpr_pkg::t_addr'(1);
            end
            mpr_pkg::S_REV_END: begin
                n_len    = mpr_pkg::t_len'(1);
                n_solved = 1'b1;
                n_turn   = mpr_pkg::T_FINISH;
                n_status = mpr_pkg::ST_SOLVED;
            end
            mpr_pkg::S_RP_DATA: begin
                n_turn = s_rdata;
                if (s_rdata == mpr_pkg::T_FINISH) begin
                    n_len    = '0;
                    n_solved = 1'b0;
                    n_status = mpr_pkg::ST_REPLAY_DONE;
                end else begin
                    n_len    = s_sum;
                    n_status = mpr_pkg::ST_OK;
                end
            end
            mpr_pkg::S_DONE: begin
                if (s_slot_free) n_out_valid = 1'b1;
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mpr_pkg::S_IDLE;
            r_len         <= '0;
            r_solved      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left_handed <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_solved    <= n_solved;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_left_handed <= i_cfg_wr_data;
        end
    end

    // Working payload registers.
    always_ff @(posedge i_clk) begin
        r_turn    <= n_turn;
        r_status  <= n_status;
        r_tmp     <= n_tmp;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_sh_addr <= n_sh_addr;
    end

    // Output register, loaded when the result beat is ready and the slot is free.
    always_ff @(posedge i_clk) begin
        if (r_state == mpr_pkg::S_DONE && s_slot_free) begin
            r_o_turn   <= r_turn;
            r_o_status <= r_status;
            r_o_count  <= r_len;
            r_o_solved <= r_solved;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_turn_cmd    = r_o_turn;
    assign o_status      = r_o_status;
    assign o_path_count  = r_o_count;
    assign o_solved_mode = r_o_solved;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for maze_path_recorder_replayer: directed junctions, then random runs.
// Depends on mpr_pkg and the block's RTL; predicts every result beat with its own route model.

module testbench;
    import mpr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE = 50;

    // One result beat as the block reports it.
    typedef struct packed {
        t_turn      turn;
        t_status    status;
        logic [5:0] count;
        logic       solved;
    } move_t;

    // One row of the directed part; the typed result is used only where known is set.
    typedef struct packed {
        logic  cmd;
        t_line entry;
        t_line hist;
        t_line ex;
        bit    known;
        move_t want;
    } junction_row_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_valid;
    logic       o_ready;
    logic       i_cmd;
    logic [2:0] i_entry_line_kind;
    logic [2:0] i_history_line_kind;
    logic [2:0] i_exit_line_kind;
    logic       o_valid;
    logic       i_ready;
    logic [2:0] o_turn_cmd;
    logic [1:0] o_status;
    logic [5:0] o_path_count;
    logic       o_solved_mode;

    maze_path_recorder_replayer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_entry_line_kind   (i_entry_line_kind),
        .i_history_line_kind (i_history_line_kind),
        .i_exit_line_kind    (i_exit_line_kind),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_turn_cmd          (o_turn_cmd),
        .o_status            (o_status),
        .o_path_count        (o_path_count),
        .o_solved_mode       (o_solved_mode)
    );

    // Route model state: recorded turns, length or replay position, replay flag, wall rule.
    t_turn      route_store [0:DEPTH-1];
    logic [5:0] route_len;
    logic       replaying;
    logic       rule_left;

    move_t         expected_moves [$];
    junction_row_t directed_rows [$];
    int            mismatches;
    int            clock_count;
    bit            no_idle;
    int            turns_to_goal;
    int            uturn_pct;
    int            clear_pct;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        clock_count <= clock_count + 1;
        if (clock_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Turn chosen at a junction under the current wall rule.
    function automatic t_turn junction_turn(input t_line e, input t_line h, input t_line x,
                                            input logic lh);
        if (e == L_NONE) return T_UTURN;
        case ({h, x})
            {L_LEFT, L_NONE}:                        return T_LEFT;
            {L_RIGHT, L_NONE}:                       return T_RIGHT;
            {L_FULL, L_NONE}, {L_FULL, L_STRAIGHT}:  return lh ? T_LEFT : T_RIGHT;
            {L_LEFT, L_STRAIGHT}:                    return lh ? T_LEFT : T_STRAIGHT;
            {L_RIGHT, L_STRAIGHT}:                   return lh ? T_STRAIGHT : T_RIGHT;
            {L_FULL, L_FULL}:                        return T_FINISH;
            default:                                 return T_STOP;
        endcase
    endfunction

    // Heading change in clockwise quarter turns.
    function automatic logic [1:0] heading_quarters(input t_turn t);
        case (t)
            T_STRAIGHT: return 2'd0;
            T_RIGHT:    return 2'd1;
            T_UTURN:    return 2'd2;
            default:    return 2'd3;
        endcase
    endfunction

    // A dead end x, u-turn, y collapses to the single turn with the same net heading.
    function automatic t_turn cut_dead_end(input t_turn a, input t_turn b);
        logic [1:0] q;
        q = heading_quarters(a) + 2'd2 + heading_quarters(b);
        case (q)
            2'd0:    return T_STRAIGHT;
            2'd1:    return T_RIGHT;
            2'd2:    return T_UTURN;
            default: return T_LEFT;
        endcase
    endfunction

    function automatic t_turn mirror_turn(input t_turn t);
        if (t == T_LEFT) return T_RIGHT;
        if (t == T_RIGHT) return T_LEFT;
        return t;
    endfunction

    // Append a turn while there is room, then try to cut a dead end at the tail.
    task automatic log_turn(input t_turn t);
        if (route_len < PATH_MAX) begin
            route_store[route_len] = t;
            route_len = route_len + 1;
            if (route_len >= 3 && route_store[route_len - 2] == T_UTURN &&
                route_store[route_len - 3] <= T_RIGHT && route_store[route_len - 1] <= T_RIGHT) begin
                route_store[route_len - 3] = cut_dead_end(route_store[route_len - 3],
                                                          route_store[route_len - 1]);
                route_len = route_len - 2;
            end
        end
    endtask

    // Turn the recorded route round for the way back and start replay at entry 1.
    task automatic mirror_route();
        int    n;
        int    i;
        t_turn tmp;
        n = route_len;
        for (i = 0; i < n / 2; i++) begin
            tmp = route_store[i];
            route_store[i] = mirror_turn(route_store[n - 1 - i]);
            route_store[n - 1 - i] = mirror_turn(tmp);
        end
        if (n % 2 != 0) route_store[n / 2] = mirror_turn(route_store[n / 2]);
        route_store[n] = T_FINISH;
        route_len = 1;
    endtask

    // Advance the route model by one accepted beat and return the result it implies.
    task automatic advance_robot(input logic c, input t_line e, input t_line h, input t_line x,
                                 output move_t res);
        t_turn   turn;
        t_status st;
        turn = T_STOP;
        st = ST_OK;
        if (c) begin
            route_len = 0;
            replaying = 1'b0;
        end else if (replaying) begin
            if (route_len > PATH_MAX) begin
                st = ST_FAILED;
            end else begin
                turn = route_store[route_len];
                route_len = route_len + 1;
                if (turn == T_FINISH) begin
                    st = ST_REPLAY_DONE;
                    route_len = 0;
                    replaying = 1'b0;
                end
            end
        end else begin
            turn = junction_turn(e, h, x, rule_left);
            if (turn == T_STOP) begin
                st = ST_FAILED;
            end else begin
                log_turn(turn);
                if (turn == T_FINISH) begin
                    mirror_route();
                    replaying = 1'b1;
                    st = ST_SOLVED;
                end
            end
        end
        res.turn = turn;
        res.status = st;
        res.count = route_len;
        res.solved = replaying;
    endtask

    // Present one junction beat after a random gap and record what it should produce.
    task automatic drive_junction(input logic c, input t_line e, input t_line h, input t_line x,
                                  input bit known, input move_t typed);
        int    gap;
        move_t got;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_entry_line_kind <= e;
        i_history_line_kind <= h;
        i_exit_line_kind <= x;
        do @(posedge i_clk); while (!o_ready);
        advance_robot(c, e, h, x, got);
        expected_moves.push_back(known ? typed : got);
    endtask

    // Drop valid and wait until every outstanding result beat has been seen.
    task automatic settle_inputs();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_rule(input logic lh);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lh;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rule_left = lh;
    endtask

    task automatic table_row(input logic c, input t_line e, input t_line h, input t_line x,
                             input bit known, input t_turn t, input t_status s,
                             input logic [5:0] n, input logic m);
        junction_row_t r;
        r.cmd = c;
        r.entry = e;
        r.hist = h;
        r.ex = x;
        r.known = known;
        r.want.turn = t;
        r.want.status = s;
        r.want.count = n;
        r.want.solved = m;
        directed_rows.push_back(r);
    endtask

    // One random beat: mostly well-formed runs to the goal and back, with some noise.
    task automatic random_junction_beat();
        int    roll;
        logic  c;
        t_line e;
        t_line h;
        t_line x;
        roll = $urandom_range(0, 99);
        c = 1'b0;
        e = $urandom_range(0, 7);
        h = $urandom_range(0, 7);
        x = $urandom_range(0, 7);
        if (replaying) begin
            if (roll < clear_pct) c = 1'b1;
        end else if (roll < clear_pct) begin
            c = 1'b1;
        end else if (roll < clear_pct + 5) begin
            // Raw noise: any line kinds at all.
        end else if (roll < clear_pct + 5 + uturn_pct) begin
            e = L_NONE;
        end else if (turns_to_goal <= 0) begin
            e = L_FULL;
            h = L_FULL;
            x = L_FULL;
            turns_to_goal = $urandom_range(2, 12);
        end else begin
            e = $urandom_range(1, 7);
            case ($urandom_range(0, 5))
                0: begin h = L_LEFT;  x = L_NONE;     end
                1: begin h = L_RIGHT; x = L_NONE;     end
                2: begin h = L_FULL;  x = L_NONE;     end
                3: begin h = L_FULL;  x = L_STRAIGHT; end
                4: begin h = L_LEFT;  x = L_STRAIGHT; end
                default: begin h = L_RIGHT; x = L_STRAIGHT; end
            endcase
            turns_to_goal--;
        end
        drive_junction(c, e, h, x, 1'b0, '0);
    endtask

    // Result side: random stalls before each beat.
    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // Compare each result beat with the oldest outstanding prediction.
    always @(posedge i_clk) begin : move_check
        move_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_moves.size() == 0) begin
                $error("unexpected result beat: turn_cmd %0d status %0d", o_turn_cmd, o_status);
                mismatches++;
            end else begin
                want = expected_moves.pop_front();
                if (o_turn_cmd !== want.turn) begin
                    $error("turn_cmd: expected %0d, got %0d", want.turn, o_turn_cmd);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_path_count !== want.count) begin
                    $error("path_count: expected %0d, got %0d", want.count, o_path_count);
                    mismatches++;
                end
                if (o_solved_mode !== want.solved) begin
                    $error("solved_mode: expected %0d, got %0d", want.solved, o_solved_mode);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence.
    initial begin : stimulus
        int phase;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid = 1'b0;
        i_cmd = 1'b0;
        i_entry_line_kind = L_NONE;
        i_history_line_kind = L_NONE;
        i_exit_line_kind = L_NONE;
        mismatches = 0;
        clock_count = 0;
        no_idle = 1'b0;
        route_len = 0;
        replaying = 1'b0;
        rule_left = 1'b0;
        turns_to_goal = 6;
        uturn_pct = 20;
        clear_pct = 3;
        for (int k = 0; k < DEPTH; k++) route_store[k] = T_STRAIGHT;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_rule(1'b0);

        // Directed part, right-hand rule: clears, rejects, dead-end cuts, goal, full replay.
        table_row(1'b1, 3'd7, 3'd7, 3'd7, 1'b1, T_STOP, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_NONE, 3'd7, 3'd7, 1'b1, T_UTURN, ST_OK, 6'd1, 1'b0);
        table_row(1'b0, 3'd7, 3'd7, 3'd7, 1'b1, T_STOP, ST_FAILED, 6'd1, 1'b0);
        table_row(1'b1, L_NONE, L_NONE, L_NONE, 1'b1, T_STOP, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_STRAIGHT, L_LEFT, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_NONE, L_NONE, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_RIGHT, L_LEFT, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_NONE, L_FULL, L_FULL, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_LEFT, L_LEFT, L_STRAIGHT, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_NONE, L_NONE, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        // A u-turn in the middle with a u-turn in front: no cut applies.
        table_row(1'b0, L_FULL, L_FULL, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_STRAIGHT, L_RIGHT, L_STRAIGHT, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_STRAIGHT, L_FULL, L_STRAIGHT, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_FULL, L_NONE, L_FULL, 1'b1, T_STOP, ST_FAILED, 6'd5, 1'b0);
        table_row(1'b0, L_FULL, L_STRAIGHT, L_STRAIGHT, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_FULL, 3'd5, 3'd6, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_FULL, L_RIGHT, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_FULL, L_FULL, L_FULL, 1'b1, T_FINISH, ST_SOLVED, 6'd1, 1'b1);
        // Replay ignores the line kinds.
        table_row(1'b0, L_NONE, L_NONE, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, 3'd7, 3'd7, 3'd7, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_FULL, L_FULL, L_FULL, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_STRAIGHT, L_LEFT, L_RIGHT, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, 3'd5, 3'd6, 3'd7, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_LEFT, L_NONE, L_FULL, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        table_row(1'b0, L_RIGHT, L_STRAIGHT, L_NONE, 1'b0, T_STRAIGHT, ST_OK, 6'd0, 1'b0);
        foreach (directed_rows[r]) begin
            drive_junction(directed_rows[r].cmd, directed_rows[r].entry, directed_rows[r].hist,
                           directed_rows[r].ex, directed_rows[r].known, directed_rows[r].want);
        end

        // Random phases; the rule changes only once every result beat is back.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_inputs();
            write_rule(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : phase == 2 ? 1'b1
                                         : logic'($urandom_range(0, 1)));
            no_idle = (phase == 3) || ($urandom_range(0, 4) == 0);
            // Some phases run long straight-through routes to overflow the turn store.
            if (phase == 2 || phase == 5) begin
                turns_to_goal = 40;
                uturn_pct = 0;
                clear_pct = 0;
            end else begin
                uturn_pct = 20;
                clear_pct = 3;
            end
            repeat (BEATS_PER_PHASE) random_junction_beat();
        end

        settle_inputs();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
